/* sv/assert_macros.svh */
// assertion macros used by the checker module
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// invariant checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, expr) \
  label: assert property (@(posedge clk) (expr)) \
    else $error("assertion failed");

`endif

/* sv/rqlf_pkg.sv */
// types, constants and the error probability table of the read filter
// depends on nothing; imported by every module of the block
package rqlf_pkg;

  // sizing
  localparam int LEN_CAP        = 1048576;
  localparam int PROB_FRAC_BITS = 32;
  localparam int PROB_W         = PROB_FRAC_BITS + 1;
  localparam int LCNT_W         = $clog2(LEN_CAP + 1);
  localparam int SUM_W          = PROB_W + $clog2(LEN_CAP);
  localparam int PROD_W         = LCNT_W + PROB_W;
  localparam int LEN_W          = 21;
  localparam int QUAL_W         = 7;
  localparam int CHAR_W         = 8;
  localparam int CNT_W          = 32;
  localparam int VERDICT_W      = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 21;
  localparam int CMP_W          = (LCNT_W > LEN_W) ? LCNT_W : LEN_W;
  localparam int TAB_DEPTH      = 1 << QUAL_W;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

  // phred encoding
  localparam logic [CHAR_W-1:0] PHRED_OFFSET = 8'd33;
  localparam logic [CHAR_W-1:0] QCHAR_HIGH   = 8'd126;
  localparam logic [QUAL_W-1:0] PHRED_TOP    = 7'd93;

  // register reset values
  localparam logic [LEN_W-1:0]  MIN_LEN_RESET    = 21'd1;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET    = 21'd1048576;
  localparam logic [QUAL_W-1:0] QUAL_FLOOR_RESET = 7'd1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_SHORT = 2'd1,
    VERDICT_LONG  = 2'd2,
    VERDICT_LOWQ  = 2'd3
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEN    = 2'd0,
    REG_MAX_LEN    = 2'd1,
    REG_QUAL_FLOOR = 2'd2
  } reg_idx_t;

  // finished read handed from front to back
  typedef struct packed {
    logic [LCNT_W-1:0] len;
    logic [SUM_W-1:0]  sum;
  } read_sum_t;

  // filter settings
  typedef struct packed {
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;
    logic [QUAL_W-1:0] qual_floor;
  } cfg_t;

  typedef logic [PROB_W-1:0] prob_tab_t [TAB_DEPTH];

  // 10^(-r/10) scaled by 10^18
  localparam logic [63:0] BASE_DEC [10] = '{
    64'd1000000000000000000, 64'd794328234724281502, 64'd630957344480193249,
    64'd501187233627272285,  64'd398107170553497251, 64'd316227766016837933,
    64'd251188643150958011,  64'd199526231496887960, 64'd158489319246111349,
    64'd125892541179416721
  };

  // 10^(-q/10) * 2^F, rounded half up, by long division on the decimal value
  function automatic prob_tab_t build_prob_tab();
    prob_tab_t       tab;
    logic [127:0]    den;
    logic [127:0]    rem;
    logic [PROB_W+1:0] acc;
    int              r;
    int              d;
    for (int q = 0; q < TAB_DEPTH; q++) begin
      r   = q % 10;
      d   = q / 10;
      den = 128'd1000000000000000000;
      for (int k = 0; k < d; k++) begin
        den = den * 128'd10;
      end
      rem = {64'd0, BASE_DEC[r]};
      acc = '0;
      if (rem >= den) begin
        acc = (PROB_W+2)'(1);
        rem = rem - den;
      end
      for (int i = 0; i <= PROB_FRAC_BITS; i++) begin
        rem = rem << 1;
        acc = acc << 1;
        if (rem >= den) begin
          acc = acc | (PROB_W+2)'(1);
          rem = rem - den;
        end
      end
      acc    = (acc + (PROB_W+2)'(1)) >> 1;
      tab[q] = acc[PROB_W-1:0];
    end
    return tab;
  endfunction

  localparam prob_tab_t PROB_TAB = build_prob_tab();

endpackage

/* sv/read_quality_length_filter_unit.sv */
// Read quality and length filter. Quality characters (phred+33) stream in one per
// cycle on the qual channel while the queue has room, with last marking the end of a
// read; each character adds its error probability 10^(-q/10) to a fixed-point sum
// with 32 fraction bits. For every read one result comes out: the verdict (too short,
// too long, low quality when sum > length * 10^(-Q/10) for the minimum mean quality
// Q, else pass), the read length and saturating per-class read counters. The front
// end takes one character every clock cycle while the queue is not full, set by its
// single table lookup and 53-bit add; the back end finishes one read per cycle while
// the result channel is not stalled, in three stages (threshold lookup, 21x33
// multiply, compare). A four-entry queue of finished reads lets either side stall on
// its own. Reads longer than 1048576 characters stop counting at that length.
// Registers are written over the cfg channel, which is always ready; the user must
// write them only while no read is in flight, which the block itself does not enforce.
// depends on rqlf_pkg, rqlf_front, rqlf_fifo and rqlf_back
module read_quality_length_filter_unit import rqlf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  qual_valid,
  output logic                  qual_ready,
  input  logic [CHAR_W-1:0]     qual_char,
  input  logic                  last,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [VERDICT_W-1:0]  verdict,
  output logic [LEN_W-1:0]      read_length,
  output logic [CNT_W-1:0]      total_reads,
  output logic [CNT_W-1:0]      kept_reads,
  output logic [CNT_W-1:0]      short_reads,
  output logic [CNT_W-1:0]      long_reads,
  output logic [CNT_W-1:0]      low_quality_reads
);

  cfg_t      cfg;
  logic      push;
  read_sum_t push_data;
  logic      pop;
  read_sum_t pop_data;
  logic      fifo_full;
  logic      fifo_empty;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_len    <= MIN_LEN_RESET;
      cfg.max_len    <= MAX_LEN_RESET;
      cfg.qual_floor <= QUAL_FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_LEN:    cfg.min_len    <= LEN_W'(cfg_data);
        REG_MAX_LEN:    cfg.max_len    <= LEN_W'(cfg_data);
        REG_QUAL_FLOOR: cfg.qual_floor <= cfg_data[QUAL_W-1:0];
        default: ;
      endcase
    end
  end

  // character intake and accumulation
  rqlf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .qual_valid (qual_valid),
    .qual_ready (qual_ready),
    .qual_char  (qual_char),
    .last       (last),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_data  (push_data)
  );

  // finished reads waiting for a verdict
  rqlf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  // verdict and counters
  rqlf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .fifo_empty        (fifo_empty),
    .fifo_data         (pop_data),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .verdict           (verdict),
    .read_length       (read_length),
    .total_reads       (total_reads),
    .kept_reads        (kept_reads),
    .short_reads       (short_reads),
    .long_reads        (long_reads),
    .low_quality_reads (low_quality_reads)
  );

endmodule

/* sv/rqlf_front.sv */
// front end: takes quality characters, accumulates length and error sum
// depends on rqlf_pkg; feeds rqlf_fifo with one entry per finished read
module rqlf_front import rqlf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              qual_valid,
  output logic              qual_ready,
  input  logic [CHAR_W-1:0] qual_char,
  input  logic              last,
  input  logic              fifo_full,
  output logic              push,
  output read_sum_t         push_data
);

  logic [LCNT_W-1:0] length_count;
  logic [SUM_W-1:0]  err_sum;
  logic [LCNT_W-1:0] length_next;
  logic [SUM_W-1:0]  sum_next;
  logic [QUAL_W-1:0] score;
  logic [PROB_W-1:0] prob;
  logic              room;
  logic              accept;

  assign qual_ready = !fifo_full;
  assign accept     = qual_valid && qual_ready;

  // clamp the character to a phred score
  always_comb begin
    if (qual_char inside {[PHRED_OFFSET:QCHAR_HIGH]}) begin
      score = QUAL_W'(qual_char - PHRED_OFFSET);
    end else if (qual_char < PHRED_OFFSET) begin
      score = '0;
    end else begin
      score = PHRED_TOP;
    end
  end

  // table lookup and accumulate, characters past the length cap are dropped
  always_comb begin
    prob = PROB_TAB[score];
    room = length_count < LCNT_W'(LEN_CAP);
    if (room) begin
      length_next = length_count + LCNT_W'(1);
      sum_next    = err_sum + SUM_W'(prob);
    end else begin
      length_next = length_count;
      sum_next    = err_sum;
    end
  end

  // hand a finished read to the queue
  assign push          = accept && last;
  assign push_data.len = length_next;
  assign push_data.sum = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_count <= '0;
      err_sum      <= '0;
    end else if (accept) begin
      if (last) begin
        length_count <= '0;
        err_sum      <= '0;
      end else begin
        length_count <= length_next;
        err_sum      <= sum_next;
      end
    end
  end

endmodule

/* sv/rqlf_fifo.sv */
// short queue of finished reads between front and back
// depends on rqlf_pkg for the entry type and depth
module rqlf_fifo import rqlf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  read_sum_t push_data,
  input  logic      pop,
  output read_sum_t pop_data,
  output logic      full,
  output logic      empty
);

  read_sum_t          entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full     = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

/* sv/rqlf_back.sv */
// back end: threshold lookup, multiply, verdict and saturating counters
// depends on rqlf_pkg; drains rqlf_fifo and drives the result channel
module rqlf_back import rqlf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 fifo_empty,
  input  read_sum_t            fifo_data,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [VERDICT_W-1:0] verdict,
  output logic [LEN_W-1:0]     read_length,
  output logic [CNT_W-1:0]     total_reads,
  output logic [CNT_W-1:0]     kept_reads,
  output logic [CNT_W-1:0]     short_reads,
  output logic [CNT_W-1:0]     long_reads,
  output logic [CNT_W-1:0]     low_quality_reads
);

  // lookup stage
  logic              a_valid;
  logic [LCNT_W-1:0] a_len;
  logic [SUM_W-1:0]  a_sum;
  logic              a_short;
  logic              a_long;
  logic [PROB_W-1:0] a_thr;
  // multiply stage
  logic              b_valid;
  logic [LCNT_W-1:0] b_len;
  logic [SUM_W-1:0]  b_sum;
  logic              b_short;
  logic              b_long;
  logic [PROD_W-1:0] b_prod;
  // stage advance
  logic              a_load;
  logic              b_load;
  logic              out_load;
  verdict_t          verdict_next;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

  assign out_load = b_valid && (!result_valid || result_ready);
  assign b_load   = a_valid && (!b_valid || out_load);
  assign a_load   = !fifo_empty && (!a_valid || b_load);
  assign pop      = a_load;

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        b_valid <= 1'b1;
      end else if (out_load) begin
        b_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // length checks and threshold lookup
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_len   <= fifo_data.len;
      a_sum   <= fifo_data.sum;
      a_short <= CMP_W'(fifo_data.len) < CMP_W'(cfg.min_len);
      a_long  <= CMP_W'(fifo_data.len) > CMP_W'(cfg.max_len);
      a_thr   <= PROB_TAB[cfg.qual_floor];
    end
  end

  // length times threshold probability
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_len   <= a_len;
      b_sum   <= a_sum;
      b_short <= a_short;
      b_long  <= a_long;
      b_prod  <= PROD_W'(a_len) * PROD_W'(a_thr);
    end
  end

  // verdict in priority order
  always_comb begin
    if (b_short) begin
      verdict_next = VERDICT_SHORT;
    end else if (b_long) begin
      verdict_next = VERDICT_LONG;
    end else if (PROD_W'(b_sum) > b_prod) begin
      verdict_next = VERDICT_LOWQ;
    end else begin
      verdict_next = VERDICT_PASS;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict     <= verdict_next;
      read_length <= LEN_W'(b_len);
    end
  end

  // saturating per-class counters, also shown on the result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      total_reads       <= '0;
      kept_reads        <= '0;
      short_reads       <= '0;
      long_reads        <= '0;
      low_quality_reads <= '0;
    end else if (out_load) begin
      total_reads <= sat_inc(total_reads);
      case (verdict_next)
        VERDICT_PASS:  kept_reads        <= sat_inc(kept_reads);
        VERDICT_SHORT: short_reads       <= sat_inc(short_reads);
        VERDICT_LONG:  long_reads        <= sat_inc(long_reads);
        VERDICT_LOWQ:  low_quality_reads <= sat_inc(low_quality_reads);
        default: ;
      endcase
    end
  end

endmodule

/* sv/rqlf_checker.sv */
// port-level checks on the read filter, bound to the top level
// depends on rqlf_pkg and assert_macros.svh
`include "assert_macros.svh"

module rqlf_checker import rqlf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic [VERDICT_W-1:0]  verdict,
  input logic [LEN_W-1:0]      read_length,
  input logic [CNT_W-1:0]      total_reads,
  input logic [CNT_W-1:0]      kept_reads,
  input logic [CNT_W-1:0]      short_reads,
  input logic [CNT_W-1:0]      long_reads,
  input logic [CNT_W-1:0]      low_quality_reads
);

  // a stalled result keeps its payload
  `ASSERT_IMPLIES(a_result_hold, clk, rst,
    !$past(rst) && $past(result_valid && !result_ready),
    result_valid && $stable(verdict) && $stable(read_length) && $stable(total_reads))

  // no result straight out of reset
  `ASSERT_IMPLIES(a_reset_clear, clk, rst, $past(rst), !result_valid)

  // the class counter of a shown verdict has counted this read
  `ASSERT_IMPLIES(a_class_counted, clk, rst, result_valid,
    (verdict != VERDICT_PASS  || kept_reads != '0) &&
    (verdict != VERDICT_SHORT || short_reads != '0) &&
    (verdict != VERDICT_LONG  || long_reads != '0) &&
    (verdict != VERDICT_LOWQ  || low_quality_reads != '0))

  // every class count is bounded by the total count
  `ASSERT_ALWAYS(a_total_bounds, clk,
    rst || (total_reads >= kept_reads && total_reads >= short_reads &&
            total_reads >= long_reads && total_reads >= low_quality_reads))

endmodule

bind read_quality_length_filter_unit rqlf_checker u_checker (.*);
